@@ hdl/tfpm_pkg.sv @@
// shared types and constants of the tracking fault persistence monitor
package tfpm_pkg;

  // widths of the fields and registers
  localparam int unsigned LimW   = 15;
  localparam int unsigned TimerW = 16;
  localparam int unsigned DtW    = 10;
  localparam int unsigned ErrW   = 16;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // command codes
  typedef enum logic [2:0] {
    CMD_UPDATE    = 3'd0,
    CMD_CLR_VERT  = 3'd1,
    CMD_CLR_LAT   = 3'd2,
    CMD_CLR_SAT   = 3'd3,
    CMD_CLR_ALL   = 3'd4
  } cmd_t;

  // degradation reasons
  typedef enum logic [1:0] {
    DEG_NONE  = 2'd0,
    DEG_VERT  = 2'd1,
    DEG_LAT   = 2'd2,
    DEG_SAT   = 2'd3
  } deg_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PITCH_LIM  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VSPEED_LIM = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BANK_LIM   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRACK_MS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SAT_MS     = 3'd4;

  // register reset values
  localparam logic [LimW-1:0]   PITCH_LIM_RST  = 15'd51;
  localparam logic [LimW-1:0]   VSPEED_LIM_RST = 15'd2048;
  localparam logic [LimW-1:0]   BANK_LIM_RST   = 15'd102;
  localparam logic [TimerW-1:0] TRACK_MS_RST   = 16'd2000;
  localparam logic [TimerW-1:0] SAT_MS_RST     = 16'd2000;

  localparam logic [TimerW-1:0] TIMER_MAX = '1;

  // input beat
  typedef struct packed {
    logic [2:0]             cmd;
    logic [DtW-1:0]         dt_ms;
    logic                   vert_engaged;
    logic                   lat_engaged;
    logic                   vertical_is_pitch;
    logic signed [ErrW-1:0] vertical_error;
    logic signed [ErrW-1:0] lateral_error;
    logic                   vertical_constrained_in;
    logic                   lateral_constrained_in;
    logic [CodeW-1:0]       constraint_code;
    logic [CodeW-1:0]       protection_code;
    logic                   act_at_limit;
  } in_t;

  // result beat
  typedef struct packed {
    logic             vertical_held;
    logic             lateral_held;
    logic [CodeW-1:0] reason_code;
    logic [1:0]       degradation;
    logic             vert_release;
    logic             lat_release;
    logic             input_rejected;
  } out_t;

endpackage

@@ hdl/tracking_fault_persistence_monitor.sv @@
// tracking fault persistence monitor: input stage, timers and result register
//
// Usage
//   in_*  : one beat per observation or command, valid/ready handshake.
//           cmd update gives one result beat; clear commands zero the named
//           timers and give none; unknown command codes are dropped.
//   out_* : result beats, valid/ready handshake, held until taken.
//   cfg_* : register writes (index, data), always ready; write only when the
//           block is idle.
// Timing
//   an update beat passes the input register and then the result register
//   before it appears on out_*; one beat per cycle is sustained while out_ready
//   is high, set by the input register and the single timer update stage after it.
// Reset
//   synchronous active-low rst_n clears the three timers, both valid flags
//   and restores the register defaults.
// Stall
//   while out_ready is low the result register holds; the input register
//   fills and in_ready drops only once both are occupied.
module tracking_fault_persistence_monitor
  import tfpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic [LimW-1:0]   pitch_lim_r, vspeed_lim_r, bank_lim_r;
  logic [TimerW-1:0] track_ms_r, sat_ms_r;

  // timers
  logic [TimerW-1:0] vtimer_r, ltimer_r, stimer_r;
  logic [TimerW-1:0] vtimer_nxt, ltimer_nxt, stimer_nxt;

  // input stage and result stage
  in_t  s1_r;
  logic s1_valid_r;
  out_t out_r, out_nxt;
  logic out_valid_r;

  logic out_free, s1_gives, s1_adv;

  // intermediate values of the update
  logic [ErrW:0]   vmag, lmag, vlim;
  logic            vcond, lcond, scond, rejected;
  logic [TimerW:0] vsum, lsum, ssum;
  logic [TimerW-1:0] vadv, ladv, sadv;

  assign cfg_ready = 1'b1;

  // handshake: the input stage moves on when its result has room or it gives none
  assign out_free  = !out_valid_r || out_ready;
  assign s1_gives  = s1_r.cmd == CMD_UPDATE;
  assign s1_adv    = s1_valid_r && (!s1_gives || out_free);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // error magnitudes, most negative value kept exact
  assign vmag = s1_r.vertical_error[ErrW-1]
              ? (ErrW+1)'(-{s1_r.vertical_error[ErrW-1], s1_r.vertical_error})
              : {1'b0, s1_r.vertical_error};
  assign lmag = s1_r.lateral_error[ErrW-1]
              ? (ErrW+1)'(-{s1_r.lateral_error[ErrW-1], s1_r.lateral_error})
              : {1'b0, s1_r.lateral_error};
  assign vlim = s1_r.vertical_is_pitch ? (ErrW+1)'(pitch_lim_r) : (ErrW+1)'(vspeed_lim_r);

  // timer conditions
  assign vcond = s1_r.vert_engaged && ((vmag > vlim) || s1_r.vertical_constrained_in);
  assign lcond = s1_r.lat_engaged
              && ((lmag > (ErrW+1)'(bank_lim_r)) || s1_r.lateral_constrained_in);
  assign scond = s1_r.act_at_limit && (s1_r.vert_engaged || s1_r.lat_engaged);
  assign rejected = s1_r.dt_ms == '0;

  // saturating accumulation
  assign vsum = {1'b0, vtimer_r} + (TimerW+1)'(s1_r.dt_ms);
  assign lsum = {1'b0, ltimer_r} + (TimerW+1)'(s1_r.dt_ms);
  assign ssum = {1'b0, stimer_r} + (TimerW+1)'(s1_r.dt_ms);
  assign vadv = !vcond ? '0 : (vsum[TimerW] ? TIMER_MAX : vsum[TimerW-1:0]);
  assign ladv = !lcond ? '0 : (lsum[TimerW] ? TIMER_MAX : lsum[TimerW-1:0]);
  assign sadv = !scond ? '0 : (ssum[TimerW] ? TIMER_MAX : ssum[TimerW-1:0]);

  // next timer values by command
  always_comb begin
    vtimer_nxt = vtimer_r;
    ltimer_nxt = ltimer_r;
    stimer_nxt = stimer_r;
    unique case (s1_r.cmd)
      CMD_UPDATE: begin
        if (!rejected) begin
          vtimer_nxt = vadv;
          ltimer_nxt = ladv;
          stimer_nxt = sadv;
        end
      end
      CMD_CLR_VERT: vtimer_nxt = '0;
      CMD_CLR_LAT:  ltimer_nxt = '0;
      CMD_CLR_SAT:  stimer_nxt = '0;
      CMD_CLR_ALL: begin
        vtimer_nxt = '0;
        ltimer_nxt = '0;
        stimer_nxt = '0;
      end
      default: ;
    endcase
  end

  // result: priority encoded degradation on the updated timers
  always_comb begin
    out_nxt = '0;
    if (rejected) begin
      out_nxt.input_rejected = 1'b1;
    end else begin
      out_nxt.vertical_held = s1_r.vert_engaged && s1_r.vertical_constrained_in;
      out_nxt.lateral_held  = s1_r.lat_engaged && s1_r.lateral_constrained_in;
      out_nxt.reason_code   = (s1_r.constraint_code != '0) ? s1_r.constraint_code
                                                           : s1_r.protection_code;
      if (vadv >= track_ms_r) begin
        out_nxt.degradation  = DEG_VERT;
        out_nxt.vert_release = 1'b1;
      end else if (ladv >= track_ms_r) begin
        out_nxt.degradation = DEG_LAT;
        out_nxt.lat_release = 1'b1;
      end else if (sadv >= sat_ms_r) begin
        out_nxt.degradation  = DEG_SAT;
        out_nxt.vert_release = s1_r.vert_engaged;
        out_nxt.lat_release  = s1_r.lat_engaged;
      end else begin
        out_nxt.degradation = DEG_NONE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vtimer_r    <= '0;
      ltimer_r    <= '0;
      stimer_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        vtimer_r <= vtimer_nxt;
        ltimer_r <= ltimer_nxt;
        stimer_r <= stimer_nxt;
      end
      if (s1_adv && s1_gives) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && s1_gives) begin
      out_r <= out_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_lim_r  <= PITCH_LIM_RST;
      vspeed_lim_r <= VSPEED_LIM_RST;
      bank_lim_r   <= BANK_LIM_RST;
      track_ms_r   <= TRACK_MS_RST;
      sat_ms_r     <= SAT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PITCH_LIM:  pitch_lim_r  <= cfg_data[LimW-1:0];
        REG_VSPEED_LIM: vspeed_lim_r <= cfg_data[LimW-1:0];
        REG_BANK_LIM:   bank_lim_r   <= cfg_data[LimW-1:0];
        REG_TRACK_MS:   track_ms_r   <= cfg_data[TimerW-1:0];
        REG_SAT_MS:     sat_ms_r     <= cfg_data[TimerW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ tb/tfpm_checker.sv @@
// result checker of the tracking fault persistence monitor testbench
module tfpm_checker
  import tfpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_t                out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers and timers
  logic [LimW-1:0]   pitch_lim;
  logic [LimW-1:0]   vspeed_lim;
  logic [LimW-1:0]   bank_lim;
  logic [TimerW-1:0] track_ms;
  logic [TimerW-1:0] sat_ms;
  logic [TimerW-1:0] vert_timer;
  logic [TimerW-1:0] lat_timer;
  logic [TimerW-1:0] sat_timer;

  out_t awaited_reports[$];
  int   mismatches = 0;
  int   waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  // magnitude of a 16 bit error, most negative value gives 32768
  function automatic logic [ErrW:0] err_magnitude(logic [ErrW-1:0] e);
    if (e[ErrW-1])
      return 17'h10000 - {1'b0, e};
    return {1'b0, e};
  endfunction

  // saturating persistence timer, cleared when its condition drops
  function automatic logic [TimerW-1:0] bump_timer(logic [TimerW-1:0] t, logic hold,
                                                   logic [DtW-1:0] dt);
    logic [TimerW:0] sum;
    if (!hold)
      return '0;
    sum = {1'b0, t} + (TimerW+1)'(dt);
    return sum[TimerW] ? TIMER_MAX : sum[TimerW-1:0];
  endfunction

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_PITCH_LIM:  pitch_lim  = val[LimW-1:0];
      REG_VSPEED_LIM: vspeed_lim = val[LimW-1:0];
      REG_BANK_LIM:   bank_lim   = val[LimW-1:0];
      REG_TRACK_MS:   track_ms   = val[TimerW-1:0];
      REG_SAT_MS:     sat_ms     = val[TimerW-1:0];
      default: ;
    endcase
  endtask

  // timer update and degradation result of one input beat
  task automatic evaluate_update(input in_t b);
    logic [LimW-1:0] vlim;
    logic            vfail;
    logic            lfail;
    out_t            r;
    case (b.cmd)
      CMD_UPDATE: begin
        r = '0;
        if (b.dt_ms == '0) begin
          // invalid observation: timers untouched, everything else zero
          r.input_rejected = 1'b1;
        end else begin
          vlim  = b.vertical_is_pitch ? pitch_lim : vspeed_lim;
          vfail = b.vert_engaged && (err_magnitude(b.vertical_error) > {2'b00, vlim});
          lfail = b.lat_engaged && (err_magnitude(b.lateral_error) > {2'b00, bank_lim});
          vert_timer = bump_timer(vert_timer,
                         b.vert_engaged && (vfail || b.vertical_constrained_in), b.dt_ms);
          lat_timer  = bump_timer(lat_timer,
                         b.lat_engaged && (lfail || b.lateral_constrained_in), b.dt_ms);
          sat_timer  = bump_timer(sat_timer,
                         b.act_at_limit && (b.vert_engaged || b.lat_engaged),
                         b.dt_ms);
          // vertical first, then lateral, then saturation
          if (vert_timer >= track_ms) begin
            r.degradation  = DEG_VERT;
            r.vert_release = 1'b1;
          end else if (lat_timer >= track_ms) begin
            r.degradation = DEG_LAT;
            r.lat_release = 1'b1;
          end else if (sat_timer >= sat_ms) begin
            r.degradation  = DEG_SAT;
            r.vert_release = b.vert_engaged;
            r.lat_release  = b.lat_engaged;
          end
          r.vertical_held = b.vert_engaged & b.vertical_constrained_in;
          r.lateral_held  = b.lat_engaged & b.lateral_constrained_in;
          r.reason_code   = (b.constraint_code != '0) ? b.constraint_code
                                                      : b.protection_code;
        end
        awaited_reports.push_back(r);
      end
      CMD_CLR_VERT: vert_timer = '0;
      CMD_CLR_LAT:  lat_timer  = '0;
      CMD_CLR_SAT:  sat_timer  = '0;
      CMD_CLR_ALL: begin
        vert_timer = '0;
        lat_timer  = '0;
        sat_timer  = '0;
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [3:0] want,
                               input logic [3:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
    end
  endtask

  task automatic check_report(input out_t got);
    out_t want;
    if (awaited_reports.size() == 0) begin
      mismatches++;
      $display("%0t: result beat expected none actual %h", $time, got);
    end else begin
      want = awaited_reports.pop_front();
      compare_field("vertical_held", 4'(want.vertical_held), 4'(got.vertical_held));
      compare_field("lateral_held", 4'(want.lateral_held), 4'(got.lateral_held));
      compare_field("reason_code", want.reason_code, got.reason_code);
      compare_field("degradation", 4'(want.degradation), 4'(got.degradation));
      compare_field("vert_release", 4'(want.vert_release), 4'(got.vert_release));
      compare_field("lat_release", 4'(want.lat_release), 4'(got.lat_release));
      compare_field("input_rejected", 4'(want.input_rejected), 4'(got.input_rejected));
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pitch_lim  = PITCH_LIM_RST;
      vspeed_lim = VSPEED_LIM_RST;
      bank_lim   = BANK_LIM_RST;
      track_ms   = TRACK_MS_RST;
      sat_ms     = SAT_MS_RST;
      vert_timer = '0;
      lat_timer  = '0;
      sat_timer  = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      // results always trail their beat, so check before predicting
      if (out_valid && out_ready)
        check_report(out_data);
      if (in_valid && in_ready)
        evaluate_update(in_data);
    end
    waiting = awaited_reports.size();
  end

endmodule

@@ tb/tb_tracking_fault_persistence_monitor.sv @@
// stimulus and verdict of the tracking fault persistence monitor testbench
module tb_tracking_fault_persistence_monitor;
  timeunit 1ns;
  timeprecision 1ps;
  import tfpm_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int PHASES     = 6;
  localparam int PHASE_BEATS = 284;

  typedef enum int {EP_QUIET, EP_VERT, EP_LAT, EP_SAT} episode_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  // limits as last written, used to aim errors at the thresholds
  logic [LimW-1:0] lim_pitch  = PITCH_LIM_RST;
  logic [LimW-1:0] lim_vspeed = VSPEED_LIM_RST;
  logic [LimW-1:0] lim_bank   = BANK_LIM_RST;

  episode_t ep_kind = EP_QUIET;
  int       ep_left = 0;
  bit       squeeze_req = 1'b0;

  tracking_fault_persistence_monitor dut (.*);
  tfpm_checker monitor_chk (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // error whose magnitude lands above, at or below a limit
  function automatic logic [ErrW-1:0] pick_error(bit over, logic [LimW-1:0] lim);
    logic [ErrW:0] m;
    int            r;
    r = $urandom_range(0, 9);
    if (r == 0)
      m = {2'b00, lim};
    else if (r == 1)
      m = {2'b00, lim} + 17'd1;
    else if (over)
      m = 17'($urandom_range(int'(lim) + 1, 32768));
    else
      m = 17'($urandom_range(0, int'(lim)));
    if ($urandom_range(0, 1))
      m = 17'h10000 - m;
    return m[ErrW-1:0];
  endfunction

  // random beat: mostly fault episodes, some clears, rejects and noise
  function automatic in_t make_item();
    in_t             b;
    logic [63:0]     raw;
    logic [LimW-1:0] vl;
    int              r;
    r   = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    b   = raw[$bits(in_t)-1:0];
    if (r < 5)
      return b;
    if (r < 10) begin
      b.cmd = 3'($urandom_range(CMD_CLR_VERT, CMD_CLR_ALL));
      return b;
    end
    if (ep_left == 0) begin
      ep_kind = episode_t'($urandom_range(EP_QUIET, EP_SAT));
      ep_left = $urandom_range(1, 90);
    end
    ep_left--;
    b.cmd = CMD_UPDATE;
    if (r < 13)
      b.dt_ms = '0;
    else if ($urandom_range(0, 3) == 0)
      b.dt_ms = 10'($urandom_range(1, 40));
    else
      b.dt_ms = 10'($urandom_range(1, 1023));
    vl = b.vertical_is_pitch ? lim_pitch : lim_vspeed;
    b.vertical_constrained_in = ($urandom_range(0, 3) == 0);
    b.lateral_constrained_in  = ($urandom_range(0, 3) == 0);
    b.act_at_limit            = ($urandom_range(0, 3) == 0);
    b.vertical_error = pick_error(1'($urandom_range(0, 1)), vl);
    b.lateral_error  = pick_error(1'($urandom_range(0, 1)), lim_bank);
    case (ep_kind)
      EP_VERT: begin
        b.vert_engaged = 1'b1;
        if ($urandom_range(0, 2) == 0)
          b.vertical_constrained_in = 1'b1;
        else
          b.vertical_error = pick_error(1'b1, vl);
      end
      EP_LAT: begin
        b.lat_engaged = 1'b1;
        if ($urandom_range(0, 2) == 0)
          b.lateral_constrained_in = 1'b1;
        else
          b.lateral_error = pick_error(1'b1, lim_bank);
      end
      EP_SAT: begin
        b.act_at_limit = 1'b1;
        if (!b.lat_engaged)
          b.vert_engaged = 1'b1;
      end
      default: ;
    endcase
    return b;
  endfunction

  // offer one input beat and wait for it to be taken; called at a falling edge
  task automatic push_beat(input in_t b, input bit calm);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // register write, then cfg_valid is dropped again before the task returns
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PITCH_LIM:  lim_pitch  = val[LimW-1:0];
      REG_VSPEED_LIM: lim_vspeed = val[LimW-1:0];
      REG_BANK_LIM:   lim_bank   = val[LimW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] pitch, input logic [CfgDataW-1:0] vspd,
                              input logic [CfgDataW-1:0] bank, input logic [CfgDataW-1:0] trk,
                              input logic [CfgDataW-1:0] sat);
    write_reg(REG_PITCH_LIM, pitch);
    write_reg(REG_VSPEED_LIM, vspd);
    write_reg(REG_BANK_LIM, bank);
    write_reg(REG_TRACK_MS, trk);
    write_reg(REG_SAT_MS, sat);
  endtask

  // stop offering, wait for all results, then let clears run through
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(negedge clk);
  endtask

  // result side: random stalls, calm stretches and the long hold-off
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc        = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = 200;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap((cyc / 300) % 4 == 0);
      end
    end
  end

  // stimulus
  initial begin
    in_t b;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats with reset limits
    // rejected step with every other bit set
    b = '1;
    b.cmd = CMD_UPDATE;
    b.dt_ms = '0;
    push_beat(b, 1'b1);
    // most negative pitch error, two longest steps reach vertical degradation
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd1023;
    b.vert_engaged = 1'b1;
    b.vertical_is_pitch = 1'b1;
    b.vertical_error = 16'sh8000;
    push_beat(b, 1'b1);
    push_beat(b, 1'b1);
    // rejected step leaves the timers alone
    b = '0;
    b.cmd = CMD_UPDATE;
    push_beat(b, 1'b1);
    // error at the limit, held by the constraint instead
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd1;
    b.vert_engaged = 1'b1;
    b.vertical_is_pitch = 1'b1;
    b.vertical_error = 16'sd51;
    b.vertical_constrained_in = 1'b1;
    push_beat(b, 1'b1);
    b = '0;
    b.cmd = CMD_CLR_VERT;
    push_beat(b, 1'b1);
    // largest positive bank error, protection code passed through then constraint code
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd1023;
    b.lat_engaged = 1'b1;
    b.lateral_error = 16'sh7fff;
    b.vert_engaged = 1'b1;
    b.vertical_error = -16'sd2048;
    b.protection_code = 4'hf;
    push_beat(b, 1'b1);
    b.constraint_code = 4'hf;
    push_beat(b, 1'b1);
    b = '0;
    b.cmd = CMD_CLR_LAT;
    push_beat(b, 1'b1);
    // saturation on the lateral axis alone, then both axes, then neither
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd1023;
    b.lat_engaged = 1'b1;
    b.act_at_limit = 1'b1;
    push_beat(b, 1'b1);
    b.dt_ms = 10'd1000;
    push_beat(b, 1'b1);
    b.dt_ms = 10'd1;
    b.vert_engaged = 1'b1;
    push_beat(b, 1'b1);
    b.vert_engaged = 1'b0;
    b.lat_engaged = 1'b0;
    push_beat(b, 1'b1);
    // every clear, then unknown commands with all bits set
    b = '0;
    b.cmd = CMD_CLR_SAT;
    push_beat(b, 1'b1);
    b.cmd = CMD_CLR_ALL;
    push_beat(b, 1'b1);
    b = '1;
    b.cmd = CMD_BAD_LO;
    push_beat(b, 1'b1);
    b.cmd = CMD_BAD_HI;
    push_beat(b, 1'b1);
    // bank error just over and exactly at the limit
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd5;
    b.lat_engaged = 1'b1;
    b.lateral_error = -16'sd103;
    push_beat(b, 1'b1);
    b.lateral_error = 16'sd102;
    push_beat(b, 1'b1);
    // vertical speed reference just over its limit
    b = '0;
    b.cmd = CMD_UPDATE;
    b.dt_ms = 10'd1;
    b.vert_engaged = 1'b1;
    b.vertical_error = 16'sd2049;
    push_beat(b, 1'b1);
    settle();

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(16'(PITCH_LIM_RST), 16'(VSPEED_LIM_RST), 16'(BANK_LIM_RST),
                        TRACK_MS_RST, SAT_MS_RST);
        1: program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        2: program_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
        3: begin
          // top bit is dropped, so the limits become zero
          program_regs(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0);
          write_reg(REG_UNUSED, 16'hffff);
        end
        default: program_regs(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                              16'($urandom_range(1, 3000)), 16'($urandom_range(1, 8000)),
                              16'($urandom_range(1, 8000)));
      endcase
      ep_left = 0;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ((p == 1 || p == 4) && i == 100)
          squeeze_req = 1'b1;
        push_beat(make_item(), (i / 50) % 4 == 1);
      end
      settle();
    end

    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
